/* rtl/core/lst_pkg.sv */
// ----------------------------------------------------------------------------
// lst_pkg
// Types, constants and small helpers for the LZW string table.
// ----------------------------------------------------------------------------
`default_nettype none

package lst_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int MAX_STRING  = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int MODE_W   = 2;
  localparam int CODE_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(127);
  localparam logic [BYTE_W-1:0] ROOT_FILL = '0;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ADD_ROOT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXTEND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET_SFX  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GET      = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LONG    = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   new_code;
    logic [BYTE_W-1:0]   data_byte;
    logic [POS_W-1:0]    position;
    logic                last;
  } res_t;

  // one entry of the link memory
  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
  } link_t;

  // memory operations issued by the sequencer
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              sfx_we;
    logic              lnk_we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] sfx_wdata;
    link_t             lnk_wdata;
  } mem_op_t;

  // sequencer status
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               walking;
  } seq_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  // code to memory address, extended or truncated
  function automatic logic [ADDR_W-1:0] code_addr(input logic [CODE_W-1:0] c);
    logic [CODE_W+ADDR_W-1:0] w;
    w = {{ADDR_W{1'b0}}, c};
    return w[ADDR_W-1:0];
  endfunction

  // entry count to code field
  function automatic logic [CODE_W-1:0] count_code(input logic [COUNT_W-1:0] n);
    logic [CODE_W+COUNT_W-1:0] w;
    w = {{CODE_W{1'b0}}, n};
    return w[CODE_W-1:0];
  endfunction

  // code already created
  function automatic logic code_known(input logic [CODE_W-1:0] c,
                                      input logic [COUNT_W-1:0] n);
    logic [CODE_W+COUNT_W-1:0] a;
    logic [CODE_W+COUNT_W-1:0] b;
    a = {{COUNT_W{1'b0}}, c};
    b = {{CODE_W{1'b0}}, n};
    return a < b;
  endfunction

  // prefix to address, out-of-range prefix folds to entry zero
  function automatic logic [ADDR_W-1:0] prefix_addr(input logic [CODE_W-1:0] p);
    logic [CODE_W+COUNT_W-1:0] a;
    a = {{COUNT_W{1'b0}}, p};
    if (a >= (CODE_W + COUNT_W)'(TABLE_DEPTH)) begin
      return '0;
    end
    return code_addr(p);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lst_ram.sv */
// ----------------------------------------------------------------------------
// lst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lst_seq.sv */
// ----------------------------------------------------------------------------
// lst_seq
// Request sequencer: checks, appends, suffix updates and the prefix-chain walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire lst_pkg::req_t              req_item,
  input  wire logic                       slot_free,
  output logic                            res_load,
  output lst_pkg::res_t                   res_next,
  output lst_pkg::mem_op_t                mem_op,
  input  wire logic [lst_pkg::BYTE_W-1:0] sfx_rd,
  input  wire lst_pkg::link_t             lnk_rd,
  output lst_pkg::seq_stat_t              stat
);

  import lst_pkg::*;

  state_t             state;
  state_t             state_next;
  req_t               req_q;
  logic [COUNT_W-1:0] count;
  logic [POS_W-1:0]   pos;

  logic               known;
  logic               full;
  logic               too_long;
  logic               append_go;
  logic               walk_start;
  logic               walk_emit;
  logic [LEN_W:0]     len_inc;
  logic [LEN_W-1:0]   len_sat;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   len_m1;

  // request checks against the registered request and read data
  assign known    = code_known(req_q.code, count);
  assign full     = (count == COUNT_W'(TABLE_DEPTH));
  assign too_long = (lnk_rd.len > LEN_W'(MAX_STRING));
  assign len_inc  = {1'b0, lnk_rd.len} + (LEN_W + 1)'(1);
  assign len_sat  = (len_inc > {1'b0, LEN_LIMIT}) ? LEN_LIMIT : len_inc[LEN_W-1:0];
  assign len_eff  = (lnk_rd.len == '0) ? LEN_W'(1) : lnk_rd.len;
  assign len_m1   = len_eff - LEN_W'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_q.mode == MODE_GET && known && !too_long) begin
          state_next = S_WALK;
        end else if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (slot_free && pos == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and memory operations
  always_comb begin
    req_ready        = 1'b0;
    res_load         = 1'b0;
    res_next         = '0;
    res_next.last    = 1'b1;
    mem_op           = '0;
    append_go        = 1'b0;
    walk_start       = 1'b0;
    walk_emit        = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready    = 1'b1;
        mem_op.re    = req_valid;
        mem_op.raddr = code_addr(req_item.code);
      end
      S_EXEC: begin
        case (req_q.mode)
          MODE_ADD_ROOT: begin
            res_load = slot_free;
            if (full) begin
              res_next.status = ST_FULL;
            end else begin
              res_next.new_code       = count_code(count);
              append_go               = slot_free;
              mem_op.sfx_we           = slot_free;
              mem_op.lnk_we           = slot_free;
              mem_op.waddr            = count[ADDR_W-1:0];
              mem_op.sfx_wdata        = req_q.value;
              mem_op.lnk_wdata.prefix = '0;
              mem_op.lnk_wdata.len    = LEN_W'(1);
            end
          end
          MODE_EXTEND: begin
            res_load = slot_free;
            if (!known) begin
              res_next.status = ST_UNKNOWN;
            end else if (full) begin
              res_next.status = ST_FULL;
            end else begin
              res_next.new_code       = count_code(count);
              append_go               = slot_free;
              mem_op.sfx_we           = slot_free;
              mem_op.lnk_we           = slot_free;
              mem_op.waddr            = count[ADDR_W-1:0];
              mem_op.sfx_wdata        = ROOT_FILL;
              mem_op.lnk_wdata.prefix = req_q.code;
              mem_op.lnk_wdata.len    = len_sat;
            end
          end
          MODE_SET_SFX: begin
            res_load = slot_free;
            if (!known) begin
              res_next.status = ST_UNKNOWN;
            end else begin
              mem_op.sfx_we    = slot_free;
              mem_op.waddr     = code_addr(req_q.code);
              mem_op.sfx_wdata = req_q.value;
            end
          end
          MODE_GET: begin
            if (!known) begin
              res_load        = slot_free;
              res_next.status = ST_UNKNOWN;
            end else if (too_long) begin
              res_load        = slot_free;
              res_next.status = ST_LONG;
            end else begin
              walk_start = 1'b1;
            end
          end
          default: begin
            res_load = 1'b0;
          end
        endcase
      end
      S_WALK: begin
        // emit the held byte, then fetch the prefix entry
        res_load           = slot_free;
        walk_emit          = slot_free;
        res_next.data_byte = sfx_rd;
        res_next.position  = pos;
        res_next.last      = (pos == '0);
        mem_op.re          = slot_free && (pos != '0);
        mem_op.raddr       = prefix_addr(lnk_rd.prefix);
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (append_go) begin
        count <= count + COUNT_W'(1);
      end
    end
  end

  // request capture and position counter
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req_item;
    end
    if (walk_start) begin
      pos <= len_m1[POS_W-1:0];
    end else if (walk_emit) begin
      pos <= pos - POS_W'(1);
    end
  end

  assign stat.count   = count;
  assign stat.walking = (state == S_WALK);

endmodule

`default_nettype wire

/* rtl/core/lzw_string_table_top.sv */
// A single-result request loads its result in the execute state after
// acceptance, once the result register is free. A get of a string of length L
// streams L bytes, one per cycle while the result register is free; no request
// is taken meanwhile, and the walk reads the link memory once per later byte.
// Reset clears the entry count and control state, not the entry memories.
// ----------------------------------------------------------------------------
// lzw_string_table_top
// LZW string table: entry memories, request sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_string_table_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire lst_pkg::req_t req_item,
  output logic               res_valid,
  input  wire logic          res_ready,
  output lst_pkg::res_t      res_item
);

  import lst_pkg::*;

  logic        slot_free;
  logic        res_load;
  res_t        res_next;
  mem_op_t     mem_op;
  logic [BYTE_W-1:0] sfx_rd;
  link_t       lnk_rd;
  seq_stat_t   stat;

  // suffix byte per entry
  lst_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_sfx_ram (
    .clk  (clk),
    .we   (mem_op.sfx_we),
    .waddr(mem_op.waddr),
    .wdata(mem_op.sfx_wdata),
    .re   (mem_op.re),
    .raddr(mem_op.raddr),
    .rdata(sfx_rd)
  );

  // prefix code and length per entry
  lst_ram #(
    .WIDTH($bits(link_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_lnk_ram (
    .clk  (clk),
    .we   (mem_op.lnk_we),
    .waddr(mem_op.waddr),
    .wdata(mem_op.lnk_wdata),
    .re   (mem_op.re),
    .raddr(mem_op.raddr),
    .rdata(lnk_rd)
  );

  lst_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_item (req_item),
    .slot_free(slot_free),
    .res_load (res_load),
    .res_next (res_next),
    .mem_op   (mem_op),
    .sfx_rd   (sfx_rd),
    .lnk_rd   (lnk_rd),
    .stat     (stat)
  );

  // result register
  assign slot_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_item <= res_next;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in flight");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status != ST_OK |-> res_item.last)
    else $error("error result without last mark");

  a_last_at_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.last |-> res_item.position == '0)
    else $error("last result not at position zero");

  a_walk_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.walking |-> !req_ready)
    else $error("request taken during chain walk");

endmodule

`default_nettype wire

/* dv/lzw_string_table_tb.sv */
// ----------------------------------------------------------------------------
// lzw_string_table testbench
// Drives add root, extend, set suffix and get requests into the string table
// and checks every streamed result against an in-bench model of the table:
// a directed opening, a prefix chain up to just past the string bound, and
// random traffic with back-pressure and one long result hold-off.
// ----------------------------------------------------------------------------

module testbench;

  import lst_pkg::*;

  // longest length a table entry can record
  localparam int LEN_CAP = 127;

  // --------------------------------------------------------------------------
  // string table model and result checker
  // --------------------------------------------------------------------------
  class string_table_model;
    logic [BYTE_W-1:0] suffix_mem [TABLE_DEPTH];
    logic [CODE_W-1:0] prefix_mem [TABLE_DEPTH];
    logic [LEN_W-1:0]  length_mem [TABLE_DEPTH];
    int unsigned       entry_total;
    res_t              pending_results [$];
    int                errors;
    int                requests;
    int                results_checked;
    int                strings_read;
    int                error_replies;

    function new();
      entry_total = 0;
      errors = 0;
      requests = 0;
      results_checked = 0;
      strings_read = 0;
      error_replies = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // single result for writes and errors
    function void push_single(input logic [STATUS_W-1:0] st, input int unsigned nc);
      res_t e;
      e = '0;
      e.status = st;
      e.new_code = nc[CODE_W-1:0];
      e.last = 1'b1;
      if (st != ST_OK) error_replies++;
      pending_results.push_back(e);
    endfunction

    function int unsigned append_entry(input logic [BYTE_W-1:0] b,
                                       input logic [CODE_W-1:0] p, input int l);
      int unsigned idx;
      idx = entry_total;
      suffix_mem[idx] = b;
      prefix_mem[idx] = p;
      length_mem[idx] = l[LEN_W-1:0];
      entry_total = idx + 1;
      return idx;
    endfunction

    // work out the results of one accepted request
    function void note_request(input req_t r);
      bit          known;
      int          l;
      int unsigned cur;
      res_t        e;
      requests++;
      known = r.code < entry_total;
      case (r.mode)
        MODE_ADD_ROOT: begin
          if (entry_total >= TABLE_DEPTH) push_single(ST_FULL, 0);
          else push_single(ST_OK, append_entry(r.value, '0, 1));
        end
        MODE_EXTEND: begin
          if (!known) push_single(ST_UNKNOWN, 0);
          else if (entry_total >= TABLE_DEPTH) push_single(ST_FULL, 0);
          else begin
            l = length_mem[r.code];
            l = l + 1;
            if (l > LEN_CAP) l = LEN_CAP;
            push_single(ST_OK, append_entry(ROOT_FILL, r.code, l));
          end
        end
        MODE_SET_SFX: begin
          if (!known) push_single(ST_UNKNOWN, 0);
          else begin
            suffix_mem[r.code] = r.value;
            push_single(ST_OK, 0);
          end
        end
        default: begin
          if (!known) push_single(ST_UNKNOWN, 0);
          else if (length_mem[r.code] > MAX_STRING) push_single(ST_LONG, 0);
          else begin
            // walk the chain, last byte first
            strings_read++;
            cur = r.code;
            for (l = length_mem[r.code] - 1; l >= 0; l--) begin
              e = '0;
              e.status = ST_OK;
              e.data_byte = suffix_mem[cur];
              e.position = l[POS_W-1:0];
              e.last = (l == 0);
              pending_results.push_back(e);
              cur = prefix_mem[cur];
            end
          end
        end
      endcase
    endfunction

    task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", results_checked, name, got, want));
    endtask

    // compare one accepted result with the oldest expectation
    task check_result(input res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 16'(got.status), 16'(want.status));
      compare_field("new_code", 16'(got.new_code), 16'(want.new_code));
      compare_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
      compare_field("position", 16'(got.position), 16'(want.position));
      compare_field("last", 16'(got.last), 16'(want.last));
      results_checked++;
    endtask

    task close_out();
      if (pending_results.size() != 0)
        report($sformatf("%0d results never arrived", pending_results.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_item;
  logic res_valid;
  logic res_ready;
  res_t res_item;

  bit hold_request;
  int long_holds;

  string_table_model table_model = new;

  lzw_string_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // clock
  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // note accepted requests and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) table_model.note_request(req_item);
      if (res_valid && res_ready) table_model.check_result(res_item);
    end
  end

  // result side: random stalls, quiet stretches, one long hold-off
  initial begin
    int stall;
    int run;
    res_ready = 1'b0;
    long_holds = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        res_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
        long_holds++;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          res_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        res_ready <= 1'b1;
        run = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
        repeat (run) @(negedge clk);
      end
    end
  end

  // offer one request and hold it until accepted; entered and left at a falling edge
  task automatic send_req(input logic [MODE_W-1:0] m, input int unsigned c,
                          input int unsigned v);
    req_t r;
    int   gap;
    r.mode = m;
    r.code = c[CODE_W-1:0];
    r.value = v[BYTE_W-1:0];
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_item <= r;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  function automatic int unsigned known_code();
    return $urandom_range(table_model.entry_total - 1, 0);
  endfunction

  // unknown-code requests spread over extend, set suffix and get
  function automatic logic [MODE_W-1:0] MODE(input int sel);
    case (sel % 3)
      0: return MODE_EXTEND;
      1: return MODE_SET_SFX;
      default: return MODE_GET;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned cur;
    int          sel;
    int          waited;
    rst = 1'b1;
    req_valid = 1'b0;
    req_item = '0;
    hold_request = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table: every code is unknown
    send_req(MODE_GET, 0, 0);
    send_req(MODE_EXTEND, 0, 8'hFF);
    send_req(MODE_SET_SFX, 0, 8'h55);
    // roots with extreme bytes, code field ignored
    send_req(MODE_ADD_ROOT, 0, 8'h00);
    send_req(MODE_ADD_ROOT, 4095, 8'hFF);
    send_req(MODE_ADD_ROOT, 12'hAAA, 8'hA5);
    send_req(MODE_ADD_ROOT, 12'h555, 8'h5A);
    // short string, rewritten last byte
    send_req(MODE_EXTEND, 1, 8'hFF);
    send_req(MODE_SET_SFX, 4, 8'h3C);
    send_req(MODE_EXTEND, 4, 8'h00);
    send_req(MODE_GET, 5, 8'hFF);
    send_req(MODE_GET, 0, 0);
    send_req(MODE_SET_SFX, 0, 8'hFF);
    send_req(MODE_GET, 0, 8'h81);
    send_req(MODE_SET_SFX, 5, 8'hC3);
    send_req(MODE_GET, 5, 0);
    // codes at and beyond the entry count
    send_req(MODE_GET, 6, 0);
    send_req(MODE_GET, 4095, 0);
    send_req(MODE_EXTEND, 4095, 0);
    send_req(MODE_SET_SFX, 4095, 8'h7E);
    send_req(MODE_EXTEND, 6, 0);

    // one long chain: last legal length and first too-long length
    send_req(MODE_ADD_ROOT, $urandom_range(0, 4095), $urandom_range(0, 255));
    cur = table_model.entry_total - 1;
    for (int n = 2; n <= 65; n++) begin
      send_req(MODE_EXTEND, cur, $urandom_range(0, 255));
      cur = table_model.entry_total - 1;
      if (n % 16 == 0) send_req(MODE_SET_SFX, cur, $urandom_range(0, 255));
      if (n inside {2, 63, 64, 65})
        send_req(MODE_GET, cur, 0);
    end

    // random traffic with one long result hold-off
    for (int i = 0; i < 20; i++) begin
      if (i == 5) hold_request = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 20) send_req(MODE_ADD_ROOT, $urandom_range(0, 4095), $urandom_range(0, 255));
      else if (sel < 45) send_req(MODE_EXTEND, known_code(), $urandom_range(0, 255));
      else if (sel < 60) send_req(MODE_SET_SFX, known_code(), $urandom_range(0, 255));
      else if (sel < 90) send_req(MODE_GET, known_code(), $urandom_range(0, 255));
      else send_req(MODE(sel), $urandom_range(4095, table_model.entry_total),
                    $urandom_range(0, 255));
    end
    req_valid <= 1'b0;

    // drain
    waited = 0;
    while (table_model.pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    table_model.close_out();

    $display("run: %0d requests, %0d results checked, %0d strings read, %0d error replies",
             table_model.requests, table_model.results_checked, table_model.strings_read,
             table_model.error_replies);
    $display("table reached %0d entries, %0d long result hold-off(s)",
             table_model.entry_total, long_holds);
    if (table_model.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // timeout
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
